>>> hw/rtl/swg_pkg.sv
// ----------------------------------------------------------------------------
// swg_pkg
// Types and codes shared by the swipe gesture recognizer and its checker.
// ----------------------------------------------------------------------------
package swg_pkg;

  // pointer event kinds; the fourth code means nothing and changes nothing
  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_MOVE    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PH_POSSIBLE = 2'd0,
    PH_BEGAN    = 2'd1,
    PH_ENDED    = 2'd2,
    PH_FAILED   = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    DIR_NONE      = 4'd0,
    DIR_RIGHT     = 4'd1,
    DIR_LEFT      = 4'd2,
    DIR_UP        = 4'd3,
    DIR_DOWN      = 4'd4,
    DIR_UPRIGHT   = 4'd5,
    DIR_DOWNRIGHT = 4'd6,
    DIR_DOWNLEFT  = 4'd7,
    DIR_UPLEFT    = 4'd8
  } dir_e;

  typedef enum logic [2:0] {
    CFG_ENABLED_DIRECTIONS = 3'd0,
    CFG_START_DISTANCE     = 3'd1,
    CFG_START_WINDOW       = 3'd2,
    CFG_FINISH_DISTANCE    = 3'd3,
    CFG_FINISH_WINDOW      = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  EnabledDirectionsRst = 8'd255;
  localparam logic [15:0] StartDistanceRst     = 16'd9;
  localparam logic [15:0] StartWindowRst       = 16'd100;
  localparam logic [15:0] FinishDistanceRst    = 16'd70;
  localparam logic [15:0] FinishWindowRst      = 16'd150;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] gesture_state;
    logic [3:0] direction;
    logic       swipe_done;
    logic       state_written;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  enabled_directions;
    logic [15:0] start_distance;
    logic [15:0] start_window;
    logic [15:0] finish_distance;
    logic [15:0] finish_window;
  } cfg_t;

endpackage

>>> hw/rtl/swg_cfg_regs.sv
// ----------------------------------------------------------------------------
// swg_cfg_regs
// Configuration register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
module swg_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [swg_pkg::CfgDataW-1:0]  cfg_data_i,
  output swg_pkg::cfg_t                 cfg_o
);
  import swg_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENABLED_DIRECTIONS: cfg_d.enabled_directions = cfg_data_i[7:0];
        CFG_START_DISTANCE:     cfg_d.start_distance     = cfg_data_i;
        CFG_START_WINDOW:       cfg_d.start_window       = cfg_data_i;
        CFG_FINISH_DISTANCE:    cfg_d.finish_distance    = cfg_data_i;
        CFG_FINISH_WINDOW:      cfg_d.finish_window      = cfg_data_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled_directions <= EnabledDirectionsRst;
      cfg_q.start_distance     <= StartDistanceRst;
      cfg_q.start_window       <= StartWindowRst;
      cfg_q.finish_distance    <= FinishDistanceRst;
      cfg_q.finish_window      <= FinishWindowRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/swg_engine.sv
// ----------------------------------------------------------------------------
// swg_engine
// Gesture state registers and the per-event update logic.
// ----------------------------------------------------------------------------
module swg_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  swg_pkg::in_item_t  item_i,
  input  swg_pkg::cfg_t      cfg_i,
  output swg_pkg::out_item_t result_o
);
  import swg_pkg::*;

  logic        pressed_q, pressed_d;
  phase_e      phase_q, phase_d;
  dir_e        dir_q, dir_d;
  logic [15:0] origin_x_q, origin_x_d;
  logic [15:0] origin_y_q, origin_y_d;
  logic [31:0] origin_time_q, origin_time_d;
  logic [31:0] begin_time_q, begin_time_d;

  logic [15:0] dx, dy;
  logic        on_x, on_y;
  dir_e        cls_dir;
  logic [2:0]  dir_bit;
  logic [31:0] start_elapsed, finish_elapsed, begin_ref;
  logic        done, written;

  assign dx = (origin_x_q > item_i.pos_x) ? origin_x_q - item_i.pos_x
                                          : item_i.pos_x - origin_x_q;
  assign dy = (origin_y_q > item_i.pos_y) ? origin_y_q - item_i.pos_y
                                          : item_i.pos_y - origin_y_q;
  assign on_x = dx >= cfg_i.start_distance;
  assign on_y = dy >= cfg_i.start_distance;

  // equal coordinates count as left or up
  always_comb begin
    if (on_x && on_y) begin
      if (origin_x_q < item_i.pos_x) begin
        cls_dir = (origin_y_q < item_i.pos_y) ? DIR_DOWNRIGHT : DIR_UPRIGHT;
      end else begin
        cls_dir = (origin_y_q < item_i.pos_y) ? DIR_DOWNLEFT : DIR_UPLEFT;
      end
    end else if (on_x) begin
      cls_dir = (origin_x_q < item_i.pos_x) ? DIR_RIGHT : DIR_LEFT;
    end else if (on_y) begin
      cls_dir = (origin_y_q < item_i.pos_y) ? DIR_DOWN : DIR_UP;
    end else begin
      cls_dir = DIR_NONE;
    end
  end

  assign dir_bit       = 3'(cls_dir - 4'd1);
  assign start_elapsed = item_i.now_ms - origin_time_q;
  // a swipe that begins on this very event measures from now
  assign begin_ref      = (phase_q == PH_BEGAN) ? begin_time_q : item_i.now_ms;
  assign finish_elapsed = item_i.now_ms - begin_ref;

  always_comb begin
    pressed_d     = pressed_q;
    phase_d       = phase_q;
    dir_d         = dir_q;
    origin_x_d    = origin_x_q;
    origin_y_d    = origin_y_q;
    origin_time_d = origin_time_q;
    begin_time_d  = begin_time_q;
    done          = 1'b0;
    written       = 1'b0;
    case (item_i.mode)
      MODE_PRESS: begin
        dir_d         = DIR_NONE;
        pressed_d     = 1'b1;
        origin_time_d = item_i.now_ms;
        begin_time_d  = '0;
        origin_x_d    = item_i.pos_x;
        origin_y_d    = item_i.pos_y;
      end
      MODE_RELEASE: begin
        pressed_d     = 1'b0;
        phase_d       = PH_POSSIBLE;
        written       = 1'b1;
        origin_time_d = item_i.now_ms;
        begin_time_d  = '0;
        origin_x_d    = '0;
        origin_y_d    = '0;
      end
      MODE_MOVE: begin
        if (pressed_q && phase_q != PH_ENDED) begin
          if (phase_q != PH_BEGAN && (on_x || on_y)) begin
            dir_d = cls_dir;
            if (cfg_i.enabled_directions[dir_bit] &&
                start_elapsed < {16'd0, cfg_i.start_window}) begin
              begin_time_d = item_i.now_ms;
              phase_d      = PH_BEGAN;
              written      = 1'b1;
            end else begin
              origin_x_d    = item_i.pos_x;
              origin_y_d    = item_i.pos_y;
              origin_time_d = item_i.now_ms;
            end
          end
          if (phase_d == PH_BEGAN &&
              (dx >= cfg_i.finish_distance || dy >= cfg_i.finish_distance)) begin
            written = 1'b1;
            if (finish_elapsed > {16'd0, cfg_i.finish_window}) begin
              origin_time_d = item_i.now_ms;
              begin_time_d  = '0;
              origin_x_d    = item_i.pos_x;
              origin_y_d    = item_i.pos_y;
              phase_d       = PH_FAILED;
              dir_d         = DIR_NONE;
            end else begin
              phase_d = PH_ENDED;
              done    = 1'b1;
            end
          end
        end
      end
      default: begin
        done    = 1'b0;
        written = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q     <= 1'b0;
      phase_q       <= PH_POSSIBLE;
      dir_q         <= DIR_NONE;
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      origin_time_q <= '0;
      begin_time_q  <= '0;
    end else if (step_i) begin
      pressed_q     <= pressed_d;
      phase_q       <= phase_d;
      dir_q         <= dir_d;
      origin_x_q    <= origin_x_d;
      origin_y_q    <= origin_y_d;
      origin_time_q <= origin_time_d;
      begin_time_q  <= begin_time_d;
    end
  end

  assign result_o.gesture_state = phase_d;
  assign result_o.direction     = dir_d;
  assign result_o.swipe_done    = done;
  assign result_o.state_written = written;

endmodule

>>> hw/rtl/swipe_gesture_recognizer.sv
// ----------------------------------------------------------------------------
// swipe_gesture_recognizer
// Eight-direction swipe recognizer for pointer press, release and move events.
// ----------------------------------------------------------------------------
// Each accepted event produces exactly one result item: it waits in the input
// register, then the gesture update runs in a single pass and lands in the
// output register. One event can be accepted every cycle; the gesture
// state registers are updated in the same cycle the result is captured, so
// consecutive events see each other's effect with no gap. Throughput drops
// only while the output side stalls. Configuration writes are taken every
// cycle and should be made while no event is in flight.
module swipe_gesture_recognizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  swg_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output swg_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [swg_pkg::CfgDataW-1:0]  cfg_data_i
);
  import swg_pkg::*;

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_valid_q;
  out_item_t result;
  out_item_t out_q;
  logic      out_valid_q;
  logic      step;

  swg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // the held item moves on when the output register is free or draining
  assign step       = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || step;

  swg_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_data_i;
    end
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/swg_checker.sv
// ----------------------------------------------------------------------------
// swg_checker
// Port-level checks for the swipe gesture recognizer, bound to the top level.
// ----------------------------------------------------------------------------
module swg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input swg_pkg::out_item_t out_data_o
);
  import swg_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a completed swipe always reports ended and a written state
  a_done_ended: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.swipe_done |->
      out_data_o.gesture_state == PH_ENDED && out_data_o.state_written)
    else $error("swipe done without ended state");

  // a gesture that has just begun carries the direction it was classified with
  a_dir_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.state_written && out_data_o.gesture_state == PH_BEGAN |->
      out_data_o.direction != DIR_NONE)
    else $error("gesture began without direction");

  // with no event in flight the input side is open
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i && !out_valid_o ##1 !in_valid_i && !out_valid_o |-> in_ready_o)
    else $error("input blocked while idle");

endmodule

bind swipe_gesture_recognizer swg_checker u_swg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
